// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the conversion unit.
// Each macro checks a property on the rising edge of the given clock and is
// switched off while the given reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/sidac_pkg.sv =====
`default_nettype none

package sidac_pkg;

  // Width of the input integer.
  localparam int VALUE_W = 32;
  // Width of one output character.
  localparam int CHAR_W = 8;
  // Decimal digits needed for the largest magnitude (2147483648).
  localparam int NUM_DIGITS = 10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  typedef logic [3:0] digit_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  // Control shared by every cell of the digit row.
  typedef struct packed {
    logic clear;     // load zero into the digit
    logic conv;      // one shift-and-correct step of the conversion
    logic shift_up;  // move digits one place toward the most significant end
  } cell_mode_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sidac_in_if.sv =====
`default_nettype none

// Input channel: one signed integer per beat.
interface sidac_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [sidac_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sidac_out_if.sv =====
`default_nettype none

// Output channel: one ASCII character per beat, flagged on the last one.
interface sidac_out_if;
  logic                          valid;
  logic                          ready;
  logic [sidac_pkg::CHAR_W-1:0] text_char;
  logic                          last_char;

  modport source (output valid, output text_char, output last_char, input ready);
  modport sink (input valid, input text_char, input last_char, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/signed_int_to_decimal_ascii_unit.sv =====
// Channel   Direction  Payload                        Meaning
// num       in         value[31:0] signed             integer to convert
// text      out        text_char[7:0], last_char      ASCII text, last flag on final char
//
// An item is accepted in idle, then converted one bit of the magnitude per
// cycle through a row of ten decimal digit cells. Emission takes ten steps,
// one per leading zero dropped and one per digit, and stalls while the output
// is held; a new item is taken only once emission ends. The minus sign goes
// out as soon as the output register is free, in conversion or before the
// first digit. Reset is synchronous, returns to idle and holds the input off.
`default_nettype none
`include "assert_macros.svh"

module signed_int_to_decimal_ascii_unit (
  input  wire logic     clk,
  input  wire logic     rst,
  sidac_in_if.sink      num,
  sidac_out_if.source   text
);

  localparam int CNT_W  = $clog2(sidac_pkg::VALUE_W);
  localparam int LEFT_W = $clog2(sidac_pkg::NUM_DIGITS + 1);

  sidac_pkg::state_t state, state_next;

  logic [sidac_pkg::VALUE_W-1:0] mag;
  logic [CNT_W-1:0]              cnt;
  logic [LEFT_W-1:0]             left;
  logic                          started;
  logic                          sign_pending;

  logic                          ovalid;
  logic [sidac_pkg::CHAR_W-1:0]  ochar;
  logic                          olast;

  sidac_pkg::cell_mode_t mode;
  sidac_pkg::digit_t     dig   [sidac_pkg::NUM_DIGITS];
  logic                  carry [sidac_pkg::NUM_DIGITS+1];
  sidac_pkg::digit_t     top_digit;

  logic accept;
  logic slot_free;
  logic sign_emit;
  logic skip;
  logic digit_step;
  logic digit_emit;
  logic conv_done;
  logic [sidac_pkg::VALUE_W-1:0] raw;

  assign raw       = num.value;
  assign top_digit = dig[sidac_pkg::NUM_DIGITS-1];
  assign slot_free = !ovalid || text.ready;
  assign conv_done = (cnt == CNT_W'(sidac_pkg::VALUE_W - 1));
  assign accept    = num.valid && num.ready;

  // Row of digit cells, least significant digit at index zero.
  assign carry[0] = mag[sidac_pkg::VALUE_W-1];
  for (genvar i = 0; i < sidac_pkg::NUM_DIGITS; i++) begin : g_cell
    sidac_pkg::digit_t below;
    if (i == 0) begin : g_first
      assign below = '0;
    end else begin : g_rest
      assign below = dig[i-1];
    end
    sidac_cell u_cell (
      .clk      (clk),
      .mode     (mode),
      .bit_in   (carry[i]),
      .digit_in (below),
      .bit_out  (carry[i+1]),
      .digit    (dig[i])
    );
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      sidac_pkg::ST_IDLE: begin
        if (num.valid) state_next = sidac_pkg::ST_CONV;
      end
      sidac_pkg::ST_CONV: begin
        if (conv_done) state_next = sidac_pkg::ST_EMIT;
      end
      sidac_pkg::ST_EMIT: begin
        if (digit_step && left == LEFT_W'(1)) state_next = sidac_pkg::ST_IDLE;
      end
      default: state_next = sidac_pkg::ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    num.ready  = 1'b0;
    sign_emit  = 1'b0;
    skip       = 1'b0;
    digit_step = 1'b0;
    digit_emit = 1'b0;
    mode       = '0;
    case (state)
      sidac_pkg::ST_IDLE: begin
        num.ready  = !rst;
        mode.clear = num.valid;
      end
      sidac_pkg::ST_CONV: begin
        mode.conv = 1'b1;
        sign_emit = sign_pending && slot_free;
      end
      sidac_pkg::ST_EMIT: begin
        sign_emit  = sign_pending && slot_free;
        // Leading zeros are dropped, but the units digit always goes out.
        skip       = !started && top_digit == '0 && left != LEFT_W'(1);
        digit_step = !sign_pending && (skip || slot_free);
        digit_emit = digit_step && !skip;
        mode.shift_up = digit_step;
      end
      default: begin
        mode = '0;
      end
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= sidac_pkg::ST_IDLE;
      cnt          <= '0;
      left         <= '0;
      started      <= 1'b0;
      sign_pending <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        sign_pending <= raw[sidac_pkg::VALUE_W-1];
        cnt          <= '0;
      end else if (sign_emit) begin
        sign_pending <= 1'b0;
      end
      if (state == sidac_pkg::ST_CONV) begin
        cnt <= cnt + CNT_W'(1);
        if (conv_done) begin
          left    <= LEFT_W'(sidac_pkg::NUM_DIGITS);
          started <= 1'b0;
        end
      end
      if (digit_step) begin
        left    <= left - LEFT_W'(1);
        started <= started || digit_emit;
      end
    end
  end

  // Magnitude shift register feeding the cell row, top bit first.
  always_ff @(posedge clk) begin
    if (accept) begin
      mag <= raw[sidac_pkg::VALUE_W-1] ? ('0 - raw) : raw;
    end else if (state == sidac_pkg::ST_CONV) begin
      mag <= {mag[sidac_pkg::VALUE_W-2:0], 1'b0};
    end
  end

  // Output register: one character beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (sign_emit || digit_emit) begin
      ovalid <= 1'b1;
    end else if (text.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sign_emit) begin
      ochar <= sidac_pkg::CHAR_MINUS;
      olast <= 1'b0;
    end else if (digit_emit) begin
      ochar <= sidac_pkg::CHAR_ZERO + sidac_pkg::CHAR_W'(top_digit);
      olast <= (left == LEFT_W'(1));
    end
  end

  assign text.valid     = ovalid;
  assign text.text_char = ochar;
  assign text.last_char = olast;

  // Checks on the sequencer and the emitted text.
  `ASSERT_IMPLIES(a_last_not_minus, clk, rst, ovalid && olast,
                  ochar != sidac_pkg::CHAR_MINUS)
  `ASSERT_IMPLIES(a_char_legal, clk, rst, ovalid,
                  ochar == sidac_pkg::CHAR_MINUS ||
                  (ochar >= sidac_pkg::CHAR_ZERO && ochar <= 8'h39))
  `ASSERT_IMPLIES(a_left_nonzero, clk, rst, state == sidac_pkg::ST_EMIT,
                  left != '0)
  `ASSERT_IMPLIES(a_sign_before_end, clk, rst,
                  state == sidac_pkg::ST_EMIT && state_next == sidac_pkg::ST_IDLE,
                  !sign_pending && digit_emit)

endmodule

`default_nettype wire

// ===== hw/rtl/sidac_cell.sv =====
`default_nettype none

// One decimal digit of the conversion row.
// In conversion it corrects its digit (add three when five or more) and shifts
// in one bit from the less significant neighbor, passing its top bit onward.
// In emission it takes the digit of the less significant neighbor; on clear it loads zero.
module sidac_cell (
  input  wire logic                  clk,
  input  wire sidac_pkg::cell_mode_t mode,
  input  wire logic                  bit_in,
  input  wire sidac_pkg::digit_t     digit_in,
  output logic                       bit_out,
  output sidac_pkg::digit_t          digit
);

  sidac_pkg::digit_t adjusted;
  sidac_pkg::digit_t digit_next;

  // Correction before the shift keeps the digit decimal after doubling.
  assign adjusted = (digit >= 4'd5) ? digit + 4'd3 : digit;
  assign bit_out  = adjusted[3];

  always_comb begin
    digit_next = digit;
    if (mode.clear) begin
      digit_next = '0;
    end else if (mode.conv) begin
      digit_next = {adjusted[2:0], bit_in};
    end else if (mode.shift_up) begin
      digit_next = digit_in;
    end
  end

  always_ff @(posedge clk) begin
    digit <= digit_next;
  end

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 380;
  localparam int IDLE_PERCENT = 18;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 40;
  localparam int CALM_FIRST   = 150;
  localparam int CALM_LAST    = 230;
  localparam int DRAIN_CYCLES = 60;
  localparam int STALL_LIMIT  = 5000;

  // One character of decimal text as it should leave the block.
  typedef struct packed {
    logic [sidac_pkg::CHAR_W-1:0] text_char;
    logic                         last_char;
  } text_beat_t;

  logic clk;
  logic rst;

  sidac_in_if  num_if ();
  sidac_out_if text_if ();

  signed_int_to_decimal_ascii_unit DUT (
    .clk  (clk),
    .rst  (rst),
    .num  (num_if),
    .text (text_if)
  );

  logic signed [sidac_pkg::VALUE_W-1:0] pending_values[$];
  text_beat_t                           expected_chars[$];

  int  values_taken = 0;
  int  chars_checked = 0;
  int  mismatches = 0;
  int  stall_cycles = 0;
  int  hold_left = 0;
  bit  hold_done = 0;
  bit  num_taken = 0;
  bit  calm;

  // Idling is switched off for a stretch in the middle of the run.
  assign calm = (values_taken >= CALM_FIRST) && (values_taken < CALM_LAST);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Expected text for one integer: sign first, then the digits of its
  // magnitude, most significant first, with the flag on the final one.
  function automatic void predict_text(input logic [sidac_pkg::VALUE_W-1:0] raw);
    logic [sidac_pkg::VALUE_W-1:0] magnitude;
    logic [sidac_pkg::CHAR_W-1:0]  digits[sidac_pkg::NUM_DIGITS];
    text_beat_t                    beat;
    int                            n_digits;
    bit                            negative;

    negative  = raw[sidac_pkg::VALUE_W-1];
    magnitude = negative ? (~raw + 1'b1) : raw;
    n_digits  = 0;
    do begin
      digits[n_digits] = sidac_pkg::CHAR_ZERO + sidac_pkg::CHAR_W'(magnitude % 10);
      magnitude        = magnitude / 10;
      n_digits++;
    end while (magnitude != 0 && n_digits < sidac_pkg::NUM_DIGITS);

    if (negative) begin
      beat.text_char = sidac_pkg::CHAR_MINUS;
      beat.last_char = 1'b0;
      expected_chars.push_back(beat);
    end
    for (int k = n_digits - 1; k >= 0; k--) begin
      beat.text_char = digits[k];
      beat.last_char = (k == 0);
      expected_chars.push_back(beat);
    end
  endfunction

  // A value with a chosen number of decimal digits and a random sign.
  function automatic logic [sidac_pkg::VALUE_W-1:0] value_with_digits(input int n_digits);
    longint lo;
    longint hi;
    longint magnitude;

    lo = 1;
    for (int k = 1; k < n_digits; k++) lo = lo * 10;
    hi = lo * 10 - 1;
    if (n_digits == 1) lo = 0;
    if (hi > 64'd2147483647) hi = 64'd2147483647;
    magnitude = lo + $urandom_range(32'(hi - lo), 0);
    if ($urandom_range(1, 0) == 1) magnitude = -magnitude;
    return sidac_pkg::VALUE_W'(magnitude);
  endfunction

  // Values just around a power of ten, or the extremes of the range.
  function automatic logic [sidac_pkg::VALUE_W-1:0] value_near_boundary();
    longint power;
    longint magnitude;

    if ($urandom_range(9, 0) == 0) begin
      return ($urandom_range(1, 0) == 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    power = 1;
    for (int k = $urandom_range(9, 0); k > 0; k--) power = power * 10;
    magnitude = power + $urandom_range(2, 0) - 1;
    if ($urandom_range(1, 0) == 1) magnitude = -magnitude;
    return sidac_pkg::VALUE_W'(magnitude);
  endfunction

  // Sampling at the rising edge: accepted integers feed the predictor,
  // accepted characters are checked against the oldest expectation.
  always @(posedge clk) begin
    text_beat_t seen;
    text_beat_t want;

    num_taken <= !rst && num_if.valid && num_if.ready;
    if (!rst) begin
      if (num_if.valid && num_if.ready) begin
        predict_text(num_if.value);
        values_taken++;
      end
      if (text_if.valid && text_if.ready) begin
        seen.text_char = text_if.text_char;
        seen.last_char = text_if.last_char;
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected beat, actual char %h last %b",
                   $time, seen.text_char, seen.last_char);
          mismatches++;
        end else begin
          want = expected_chars.pop_front();
          if (seen.text_char !== want.text_char) begin
            $display("%0t: text_char expected %h actual %h",
                     $time, want.text_char, seen.text_char);
            mismatches++;
          end
          if (seen.last_char !== want.last_char) begin
            $display("%0t: last_char expected %b actual %b",
                     $time, want.last_char, seen.last_char);
            mismatches++;
          end
        end
        chars_checked++;
      end
      if ((num_if.valid && num_if.ready) || (text_if.valid && text_if.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
  end

  // Sender: offers the next integer once the previous beat has gone,
  // with random gaps outside the calm stretch.
  always @(negedge clk) begin
    if (rst) begin
      num_if.valid <= 1'b0;
    end else if (!num_if.valid || num_taken) begin
      if (pending_values.size() > 0 &&
          (calm || $urandom_range(99, 0) >= IDLE_PERCENT)) begin
        num_if.valid <= 1'b1;
        num_if.value <= pending_values.pop_front();
      end else begin
        num_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off early in the
  // run so the block fills up and has to stall its input.
  always @(negedge clk) begin
    if (rst) begin
      text_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      text_if.ready <= 1'b0;
      hold_left--;
    end else if (!hold_done && values_taken >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      text_if.ready <= 1'b0;
    end else begin
      text_if.ready <= calm || ($urandom_range(99, 0) >= IDLE_PERCENT);
    end
  end

  // Watchdog on cycles in which no beat moves on either side.
  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int total_items;
    int pick;

    rst           = 1'b1;
    num_if.valid  = 1'b0;
    num_if.value  = '0;
    text_if.ready = 1'b0;

    // Directed values: zero, single digits, powers of ten and their
    // neighbors, and both ends of the range including the most negative.
    pending_values.push_back(32'sd0);
    pending_values.push_back(32'sd1);
    pending_values.push_back(-32'sd1);
    pending_values.push_back(32'sd9);
    pending_values.push_back(32'sd10);
    pending_values.push_back(-32'sd10);
    pending_values.push_back(32'sd99);
    pending_values.push_back(32'sd100);
    pending_values.push_back(-32'sd5);
    pending_values.push_back(32'sd999999999);
    pending_values.push_back(-32'sd999999999);
    pending_values.push_back(32'sd1000000000);
    pending_values.push_back(-32'sd1000000000);
    pending_values.push_back(32'sd1234567890);
    pending_values.push_back(32'sd2147483646);
    pending_values.push_back(32'sh7FFF_FFFF);
    pending_values.push_back(-32'sd2147483647);
    pending_values.push_back(32'sh8000_0000);
    pending_values.push_back(32'sh5555_5555);
    pending_values.push_back(32'shAAAA_AAAA);

    // Random values: many digit counts, small values, boundaries and raw bits.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(99, 0);
      if (pick < 30) begin
        pending_values.push_back($urandom);
      end else if (pick < 70) begin
        pending_values.push_back(value_with_digits($urandom_range(10, 1)));
      end else if (pick < 85) begin
        pending_values.push_back(sidac_pkg::VALUE_W'($urandom_range(40, 0) - 20));
      end else begin
        pending_values.push_back(value_near_boundary());
      end
    end
    total_items = pending_values.size();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Wait for every integer to go in and every character to come out.
    while (values_taken < total_items || expected_chars.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
